FILE: design/lanc_frame_transceiver_assert.svh
// Assertion macros used by the transceiver top-level file.
`ifndef LANC_FRAME_TRANSCEIVER_ASSERT_SVH
`define LANC_FRAME_TRANSCEIVER_ASSERT_SVH

// The condition must hold whenever the trigger holds, in the same cycle.
`define LFT_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("transceiver check failed");

// The condition must hold in the cycle after the trigger.
`define LFT_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("transceiver check failed");

`endif

FILE: design/lft_pkg.sv
package lft_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int BYTE_CNT_W  = $clog2(FRAME_BYTES);
  localparam int DATA_BITS   = 8;

  localparam logic [15:0] BIT_TICKS_RST  = 16'd104;
  localparam logic [14:0] HALF_TICKS_RST = 15'd52;
  localparam logic [15:0] SYNC_TICKS_RST = 16'd5000;
  localparam logic [2:0]  REPEAT_RST     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RISE,
    PH_MEASURE,
    PH_START,
    PH_BIT,
    PH_STOPHALF,
    PH_STOPWAIT
  } phase_t;

  typedef enum logic [1:0] {
    REG_BIT_TICKS,
    REG_HALF_TICKS,
    REG_SYNC_TICKS,
    REG_REPEAT
  } reg_addr_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [14:0] half_bit_ticks;
    logic [15:0] sync_pause_ticks;
    logic [2:0]  repeat_count;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic        line_level;
    logic [7:0]  second_command_byte;
    logic [7:0]  first_command_byte;
  } item_t;

  typedef struct packed {
    logic        transfer_done;
    logic        byte_valid;
    logic [2:0]  frame_number;
    logic [7:0]  byte_value;
    logic [2:0]  byte_index;
    logic        busy_res;
    logic        drive_line;
  } result_t;

endpackage

FILE: design/lanc_frame_transceiver.sv
// Master-side transceiver for a single-wire camera remote bus. Every request
// on the input stream is one bus tick with the sampled line level, or a start
// request that loads two command bytes; every request yields exactly one
// result request carrying the line drive, busy flag and any finished byte.
// One request is taken per clock cycle until a stalled consumer fills both
// result buffer entries and the input register. It is held in the input
// register, passes through a single layer of decode and counter logic, and
// lands in a two-entry result buffer, from which its result is offered on the
// output. The user must write timing registers over the APB-style port only
// while no request is in flight; the block does not enforce this. A new value
// applies from the next request on.
`include "lanc_frame_transceiver_assert.svh"

module lanc_frame_transceiver
  import lft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] first_command_byte, [15:8] second_command_byte, [16] line_level
  input  logic [23:0] s_tdata,
  // [0] command
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_line, [1] busy_res, [4:2] byte_index, [12:5] byte_value,
  // [15:13] frame_number
  output logic [15:0] m_tdata,
  // [0] byte_valid
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  item_t      in_item;
  result_t    res, out_res;
  logic       res_push, buf_space;
  logic [1:0] fill;

  assign pready = 1'b1;

  assign in_item.command             = cmd_t'(s_tuser);
  assign in_item.line_level          = s_tdata[16];
  assign in_item.second_command_byte = s_tdata[15:8];
  assign in_item.first_command_byte  = s_tdata[7:0];

  lft_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  lft_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .buf_space (buf_space),
    .res_push  (res_push),
    .res       (res)
  );

  lft_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .space     (buf_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res),
    .fill      (fill)
  );

  assign m_tdata = {out_res.frame_number, out_res.byte_value, out_res.byte_index,
                    out_res.busy_res, out_res.drive_line};
  assign m_tuser = out_res.byte_valid;
  assign m_tlast = out_res.transfer_done;

  // A finished transfer is always reported together with its last byte.
  `LFT_ASSERT_SAME(a_done_has_byte, m_tvalid && m_tlast, m_tuser)
  // Byte fields stay clear on results that carry no byte.
  `LFT_ASSERT_SAME(a_no_byte_clear, m_tvalid && !m_tuser, m_tdata[15:2] == 14'd0)
  // The core never pushes into a full result buffer.
  `LFT_ASSERT_SAME(a_no_overflow, res_push, fill != 2'd2)
  // A push with no pop grows the buffer by one entry.
  `LFT_ASSERT_NEXT(a_fill_grows, res_push && !(m_tvalid && m_tready),
                   fill == $past(fill) + 2'd1)

endmodule

FILE: design/lft_cfg_regs.sv
module lft_cfg_regs
  import lft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  logic      wr_en;
  reg_addr_t addr;

  assign addr  = reg_addr_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks        <= BIT_TICKS_RST;
      cfg.half_bit_ticks   <= HALF_TICKS_RST;
      cfg.sync_pause_ticks <= SYNC_TICKS_RST;
      cfg.repeat_count     <= REPEAT_RST;
    end else if (wr_en) begin
      unique case (addr)
        REG_BIT_TICKS:  cfg.bit_ticks        <= pwdata[15:0];
        REG_HALF_TICKS: cfg.half_bit_ticks   <= pwdata[14:0];
        REG_SYNC_TICKS: cfg.sync_pause_ticks <= pwdata[15:0];
        REG_REPEAT:     cfg.repeat_count     <= pwdata[2:0];
        default:        cfg.repeat_count     <= cfg.repeat_count;
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      REG_BIT_TICKS:  prdata = {16'd0, cfg.bit_ticks};
      REG_HALF_TICKS: prdata = {17'd0, cfg.half_bit_ticks};
      REG_SYNC_TICKS: prdata = {16'd0, cfg.sync_pause_ticks};
      REG_REPEAT:     prdata = {29'd0, cfg.repeat_count};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/lft_core.sv
module lft_core
  import lft_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  item_t   in_item,
  input  logic    buf_space,
  output logic    res_push,
  output result_t res
);

  logic  hold_valid;
  item_t hold;
  logic  advance;

  phase_t                phase, phase_next;
  logic [15:0]           tick_count, tick_count_next;
  logic [15:0]           high_count, high_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [BYTE_CNT_W-1:0] byte_count, byte_count_next;
  logic [2:0]            frames_left, frames_left_next;
  logic [2:0]            frame_no, frame_no_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [15:0]           command_bits, command_bits_next;
  logic                  previous_level, previous_level_next;

  logic [15:0] eff_bit, half_min1, eff_half;
  logic [16:0] tick_inc;
  logic        rep_valid, rep_done;
  logic [2:0]  rep_index, rep_frame;
  logic [7:0]  rep_value;

  // The held item is processed as soon as the result buffer has room.
  assign advance  = hold_valid && buf_space;
  assign in_ready = !hold_valid || buf_space;
  assign res_push = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_item;
    end
  end

  assign eff_bit   = (cfg.bit_ticks == 16'd0) ? 16'd1 : cfg.bit_ticks;
  assign half_min1 = (cfg.half_bit_ticks == 15'd0) ? 16'd1 : {1'b0, cfg.half_bit_ticks};
  assign eff_half  = (half_min1 > eff_bit) ? eff_bit : half_min1;

  // Next state. Phases fall through in order: the edge that ends the pause or
  // the stop wait already counts as the first tick of the start bit.
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    high_count_next     = high_count;
    bit_index_next      = bit_index;
    byte_count_next     = byte_count;
    frames_left_next    = frames_left;
    frame_no_next       = frame_no;
    shift_byte_next     = shift_byte;
    command_bits_next   = command_bits;
    previous_level_next = previous_level;
    rep_valid           = 1'b0;
    rep_done            = 1'b0;
    rep_index           = 3'd0;
    rep_value           = 8'd0;
    rep_frame           = 3'd0;
    tick_inc            = 17'd0;

    if (hold.command == CMD_START) begin
      if (phase == PH_IDLE) begin
        command_bits_next   = {hold.second_command_byte, hold.first_command_byte};
        frames_left_next    = (cfg.repeat_count == 3'd0) ? 3'd1 : cfg.repeat_count;
        frame_no_next       = 3'd0;
        byte_count_next     = '0;
        bit_index_next      = 3'd0;
        tick_count_next     = 16'd0;
        high_count_next     = 16'd0;
        shift_byte_next     = 8'd0;
        previous_level_next = hold.line_level;
        phase_next          = PH_RISE;
      end
    end else begin
      if (phase_next == PH_RISE) begin
        if (!previous_level && hold.line_level) begin
          high_count_next = 16'd1;
          phase_next      = PH_MEASURE;
        end
      end else if (phase_next == PH_MEASURE) begin
        if (hold.line_level) begin
          if (high_count_next != 16'hFFFF) begin
            high_count_next = high_count_next + 16'd1;
          end
        end else if (high_count_next >= cfg.sync_pause_ticks) begin
          high_count_next = 16'd0;
          byte_count_next = '0;
          tick_count_next = 16'd0;
          phase_next      = PH_START;
        end else begin
          high_count_next = 16'd0;
          phase_next      = PH_RISE;
        end
      end

      if (phase_next == PH_STOPWAIT && !hold.line_level) begin
        tick_count_next = 16'd0;
        phase_next      = PH_START;
      end

      tick_inc = {1'b0, tick_count_next} + 17'd1;
      if (phase_next == PH_START) begin
        if (tick_inc >= {1'b0, eff_bit}) begin
          tick_count_next = 16'd0;
          bit_index_next  = 3'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_BIT;
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end else if (phase_next == PH_BIT) begin
        if (tick_inc == {1'b0, eff_half} && !hold.line_level) begin
          shift_byte_next[bit_index_next] = 1'b1;
        end
        if (tick_inc >= {1'b0, eff_bit}) begin
          tick_count_next = 16'd0;
          if (bit_index_next == 3'(DATA_BITS - 1)) begin
            rep_valid = 1'b1;
            rep_index = 3'(byte_count_next);
            rep_value = shift_byte_next;
            rep_frame = frame_no_next;
            if (byte_count_next == BYTE_CNT_W'(FRAME_BYTES - 1)) begin
              if (frames_left_next != 3'd0) begin
                frames_left_next = frames_left_next - 3'd1;
              end
              if (frames_left_next == 3'd0) begin
                rep_done   = 1'b1;
                phase_next = PH_IDLE;
              end else begin
                frame_no_next   = frame_no_next + 3'd1;
                byte_count_next = '0;
                phase_next      = PH_STOPHALF;
              end
            end else begin
              byte_count_next = byte_count_next + BYTE_CNT_W'(1);
              phase_next      = PH_STOPHALF;
            end
            bit_index_next = 3'd0;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
          end
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end else if (phase_next == PH_STOPHALF) begin
        if (tick_inc >= {1'b0, eff_half}) begin
          tick_count_next = 16'd0;
          phase_next      = PH_STOPWAIT;
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end

      previous_level_next = hold.line_level;
    end
  end

  // Result of this tick, taken from the state it leaves behind.
  always_comb begin
    res.drive_line    = 1'b0;
    if (phase_next == PH_BIT &&
        (byte_count_next == '0 || byte_count_next == BYTE_CNT_W'(1))) begin
      res.drive_line = command_bits_next[{byte_count_next[0], bit_index_next}];
    end
    res.busy_res      = (phase_next != PH_IDLE);
    res.byte_valid    = rep_valid;
    res.byte_index    = rep_index;
    res.byte_value    = rep_value;
    res.frame_number  = rep_frame;
    res.transfer_done = rep_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= 16'd0;
      high_count     <= 16'd0;
      bit_index      <= 3'd0;
      byte_count     <= '0;
      frames_left    <= 3'd0;
      frame_no       <= 3'd0;
      shift_byte     <= 8'd0;
      command_bits   <= 16'd0;
      previous_level <= 1'b1;
    end else if (advance) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      high_count     <= high_count_next;
      bit_index      <= bit_index_next;
      byte_count     <= byte_count_next;
      frames_left    <= frames_left_next;
      frame_no       <= frame_no_next;
      shift_byte     <= shift_byte_next;
      command_bits   <= command_bits_next;
      previous_level <= previous_level_next;
    end
  end

endmodule

FILE: design/lft_out_buf.sv
module lft_out_buf
  import lft_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data,
  output logic [1:0] fill
);

  result_t    entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = entry[rd_ptr];
  assign fill      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: tb/tb_lanc_frame_transceiver.sv
module tb_lanc_frame_transceiver;
  timeunit 1ns;
  timeprecision 1ps;
  import lft_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 700;
  localparam result_t RES_IDLE = '0;
  localparam result_t RES_BUSY = 18'd2;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       line;
    logic       known;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the transceiver state, advanced once per accepted request.
  cfg_t        cfg;
  phase_t      ph;
  logic [15:0] tick_cnt;
  logic [15:0] high_cnt;
  logic [2:0]  bit_pos;
  logic [3:0]  byte_pos;
  logic [2:0]  frames_left;
  logic [2:0]  frame_cnt;
  logic [7:0]  rx_byte;
  logic [15:0] cmd_bits;
  logic        prev_line;

  result_t pending_results[$];
  int      errors;
  int      items_sent;
  int      send_calm;
  int      recv_calm;

  // Power-on checks: idle ticks, a start with the line already high, a start
  // while busy, and a pause that ends too early under the reset timing.
  stim_row_t directed_rows [11] = '{
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_IDLE},
    '{CMD_TICK,  8'hFF, 8'hFF, 1'b0, 1'b1, RES_IDLE},
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_IDLE},
    '{CMD_START, 8'hFF, 8'hFF, 1'b1, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_BUSY},
    '{CMD_START, 8'h00, 8'h00, 1'b0, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b0, 1'b1, RES_BUSY},
    '{CMD_TICK,  8'h00, 8'h00, 1'b1, 1'b1, RES_BUSY}
  };

  lanc_frame_transceiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t predict_bus_tick(item_t it);
    result_t     res;
    logic [15:0] full_bit;
    logic [15:0] half_bit;
    logic        line;
    res = '0;
    line = it.line_level;
    full_bit = (cfg.bit_ticks == 16'd0) ? 16'd1 : cfg.bit_ticks;
    half_bit = (cfg.half_bit_ticks == 15'd0) ? 16'd1 : {1'b0, cfg.half_bit_ticks};
    if (half_bit > full_bit) half_bit = full_bit;
    if (it.command == CMD_START) begin
      if (ph == PH_IDLE) begin
        cmd_bits = {it.second_command_byte, it.first_command_byte};
        frames_left = (cfg.repeat_count == 3'd0) ? 3'd1 : cfg.repeat_count;
        frame_cnt = '0;
        byte_pos = '0;
        bit_pos = '0;
        tick_cnt = '0;
        high_cnt = '0;
        rx_byte = '0;
        // The high level already on the line does not count toward the pause.
        prev_line = line;
        ph = PH_RISE;
      end
    end else begin
      if (ph == PH_RISE) begin
        if (!prev_line && line) begin
          high_cnt = 16'd1;
          ph = PH_MEASURE;
        end
      end else if (ph == PH_MEASURE) begin
        if (line) begin
          if (high_cnt != 16'hFFFF) high_cnt++;
        end else if (high_cnt >= cfg.sync_pause_ticks) begin
          high_cnt = '0;
          byte_pos = '0;
          tick_cnt = '0;
          ph = PH_START;
        end else begin
          high_cnt = '0;
          ph = PH_RISE;
        end
      end
      if (ph == PH_STOPWAIT && !line) begin
        tick_cnt = '0;
        ph = PH_START;
      end
      case (ph)
        PH_START: begin
          tick_cnt++;
          if (tick_cnt >= full_bit) begin
            tick_cnt = '0;
            bit_pos = '0;
            rx_byte = '0;
            ph = PH_BIT;
          end
        end
        PH_BIT: begin
          tick_cnt++;
          if (tick_cnt == half_bit && !line) rx_byte[bit_pos] = 1'b1;
          if (tick_cnt >= full_bit) begin
            tick_cnt = '0;
            if (bit_pos == 3'd7) begin
              res.byte_valid = 1'b1;
              res.byte_index = byte_pos[2:0];
              res.byte_value = rx_byte;
              res.frame_number = frame_cnt;
              if (byte_pos + 1 >= FRAME_BYTES) begin
                if (frames_left != 3'd0) frames_left--;
                if (frames_left == 3'd0) begin
                  res.transfer_done = 1'b1;
                  ph = PH_IDLE;
                end else begin
                  frame_cnt++;
                  byte_pos = '0;
                  ph = PH_STOPHALF;
                end
              end else begin
                byte_pos++;
                ph = PH_STOPHALF;
              end
              bit_pos = '0;
            end else begin
              bit_pos++;
            end
          end
        end
        PH_STOPHALF: begin
          tick_cnt++;
          if (tick_cnt >= half_bit) begin
            tick_cnt = '0;
            ph = PH_STOPWAIT;
          end
        end
        default: ;
      endcase
      prev_line = line;
    end
    if (ph == PH_BIT && byte_pos < 2) res.drive_line = cmd_bits[{byte_pos[0], bit_pos}];
    res.busy_res = (ph != PH_IDLE);
    return res;
  endfunction

  // Mostly back to back, sometimes a few cycles, rarely a long gap; now and
  // then a stretch with no gaps at all.
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r == 0) calm = $urandom_range(50, 300);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic send_item(input item_t it, input logic known, input result_t want);
    int      gap;
    result_t res;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.command;
    s_tdata <= {7'd0, it.line_level, it.second_command_byte, it.first_command_byte};
    do @(posedge clk); while (!s_tready);
    res = predict_bus_tick(it);
    pending_results.push_back(known ? want : res);
    items_sent++;
  endtask

  // Registers change only with nothing in flight.
  task automatic write_reg(input reg_addr_t which, input logic [31:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (which)
      REG_BIT_TICKS:  cfg.bit_ticks = value[15:0];
      REG_HALF_TICKS: cfg.half_bit_ticks = value[14:0];
      REG_SYNC_TICKS: cfg.sync_pause_ticks = value[15:0];
      default:        cfg.repeat_count = value[2:0];
    endcase
  endtask

  task automatic idle_noise(input int count);
    item_t it;
    repeat (count) begin
      it.command = CMD_TICK;
      it.first_command_byte = $urandom;
      it.second_command_byte = $urandom;
      it.line_level = $urandom;
      send_item(it, 1'b0, RES_IDLE);
    end
  endtask

  // Plays the camera side of the bus: a pause, then start bits and data bits
  // with the line pulled low wherever the transceiver sends a one.
  task automatic run_transfer(input int noise_pct, input int extra_high,
                              input logic short_pauses);
    item_t it;
    int    high_run;
    int    fall_at;
    logic  data_level;
    it.command = CMD_START;
    it.first_command_byte = $urandom;
    it.second_command_byte = $urandom;
    it.line_level = $urandom;
    send_item(it, 1'b0, RES_IDLE);
    high_run = 0;
    fall_at = cfg.sync_pause_ticks + extra_high;
    data_level = 1'b1;
    while (ph != PH_IDLE) begin
      it.command = CMD_TICK;
      it.first_command_byte = $urandom;
      it.second_command_byte = $urandom;
      if ($urandom_range(99) < noise_pct) begin
        it.command = cmd_t'($urandom_range(1));
        it.line_level = $urandom;
      end else begin
        case (ph)
          PH_RISE: begin
            it.line_level = !prev_line;
            if (short_pauses && $urandom_range(3) == 0)
              fall_at = $urandom_range(0, cfg.sync_pause_ticks);
            else
              fall_at = cfg.sync_pause_ticks + extra_high;
          end
          PH_MEASURE: it.line_level = (high_run < fall_at);
          PH_START: it.line_level = 1'b0;
          PH_BIT: begin
            if (tick_cnt == 16'd0) data_level = $urandom;
            it.line_level = data_level && !(byte_pos < 2 && cmd_bits[{byte_pos[0], bit_pos}]);
          end
          PH_STOPHALF: it.line_level = 1'b1;
          default: it.line_level = ($urandom_range(3) != 0);
        endcase
      end
      if (ph == PH_MEASURE && it.command == CMD_TICK && it.line_level) high_run++;
      else high_run = 0;
      send_item(it, 1'b0, RES_IDLE);
    end
  endtask

  initial begin
    int stall;
    m_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.drive_line = m_tdata[0];
      got.busy_res = m_tdata[1];
      got.byte_index = m_tdata[4:2];
      got.byte_value = m_tdata[12:5];
      got.frame_number = m_tdata[15:13];
      got.byte_valid = m_tuser;
      got.transfer_done = m_tlast;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("drive_line", want.drive_line, got.drive_line);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("byte_valid", want.byte_valid, got.byte_valid);
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("byte_value", want.byte_value, got.byte_value);
        check_field("frame_number", want.frame_number, got.frame_number);
        check_field("transfer_done", want.transfer_done, got.transfer_done);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    item_t it;
    int    base;
    int    bit_len;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    items_sent = 0;
    send_calm = 0;
    recv_calm = 0;
    cfg = {BIT_TICKS_RST, HALF_TICKS_RST, SYNC_TICKS_RST, REPEAT_RST};
    ph = PH_IDLE;
    tick_cnt = '0;
    high_cnt = '0;
    bit_pos = '0;
    byte_pos = '0;
    frames_left = '0;
    frame_cnt = '0;
    rx_byte = '0;
    cmd_bits = '0;
    prev_line = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      it.command = directed_rows[i].cmd;
      it.first_command_byte = directed_rows[i].first_byte;
      it.second_command_byte = directed_rows[i].second_byte;
      it.line_level = directed_rows[i].line;
      send_item(it, directed_rows[i].known, directed_rows[i].want);
    end
    // Shorten the timing in the middle of the pause and finish the all-ones
    // command, which keeps the four frames set at its start from the reset repeat count.
    write_reg(REG_BIT_TICKS, 32'd1);
    write_reg(REG_HALF_TICKS, 32'd1);
    write_reg(REG_SYNC_TICKS, 32'd16);
    write_reg(REG_REPEAT, 32'd7);
    run_transfer(0, 1, 1'b0);

    write_reg(REG_BIT_TICKS, 32'hFFFF);
    write_reg(REG_HALF_TICKS, 32'h7FFF);
    write_reg(REG_SYNC_TICKS, 32'hFFFF);
    write_reg(REG_REPEAT, 32'd7);
    idle_noise(8);

    // Zero timing and zero repeat fall back to one tick and one frame.
    write_reg(REG_BIT_TICKS, 32'd0);
    write_reg(REG_HALF_TICKS, 32'd0);
    write_reg(REG_SYNC_TICKS, 32'd0);
    write_reg(REG_REPEAT, 32'd0);
    run_transfer(0, 2, 1'b1);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      bit_len = $urandom_range(0, 4);
      write_reg(REG_BIT_TICKS, bit_len);
      write_reg(REG_HALF_TICKS, $urandom_range(0, bit_len + 2));
      write_reg(REG_SYNC_TICKS, $urandom_range(0, 40));
      write_reg(REG_REPEAT, $urandom_range(0, 3));
      repeat ($urandom_range(1, 2)) begin
        idle_noise($urandom_range(0, 6));
        run_transfer(($urandom_range(3) == 0) ? 5 : 0, $urandom_range(0, 6), 1'b1);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
